FILE: rtl/mapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mapd_pkg;

  localparam int CHANNELS   = 4;
  localparam int MAX_WINDOW = 256;

  localparam int CH_W    = 2;
  localparam int SMP_W   = 16;
  localparam int CIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = $clog2(MAX_WINDOW * 65535 + 1);
  localparam int RING_DEPTH = CHANNELS * MAX_WINDOW;
  localparam int RA_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WL_W    = 9;

  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [15:0]     KP_RST    = 16'd1280;
  localparam logic [15:0]     KD_RST    = 16'd256;
  localparam logic [14:0]     RANGE_RST = 15'd12868;
  localparam logic [WL_W-1:0] WL_RST    = 9'd200;

  typedef enum logic [1:0] {
    CFG_KP    = 2'd0,
    CFG_KD    = 2'd1,
    CFG_RANGE = 2'd2,
    CFG_WIN   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
  } meta_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] kd;
    logic [14:0] range;
    logic [15:0] avg;
    logic [15:0] ang_e;
    logic [15:0] ang_o;
    logic [15:0] spd_e;
    logic [15:0] spd_o;
  } pd_req_t;

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] torque_e;
    logic [15:0] torque_o;
    logic        clip;
  } pd_res_t;

  // fold a channel field into range by repeated subtract
  function automatic logic [CIDX_W-1:0] chan_idx(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] v;
    begin
      v = ch;
      for (int i = 0; i < 4; i++) begin
        if (int'(v) >= CHANNELS) begin
          v = v - CH_W'(CHANNELS);
        end
      end
      chan_idx = CIDX_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mapd_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mapd_div
  import mapd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int IT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] div_r;
  logic [IT_W-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    ge    = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[SUM_W-2:0], ge};
        rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/mapd_pd.sv
`timescale 1ns / 1ps
`default_nettype none

module mapd_pd
  import mapd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire pd_req_t req,
  output logic         done,
  output pd_res_t      res
);

  typedef enum logic [2:0] {
    P_RNG, P_KDE, P_KPE, P_KDO, P_KPO, P_ACC, P_FIN
  } pd_step_t;

  pd_step_t                  step_r;
  logic                      busy_r;
  logic                      done_r;
  pd_req_t                   req_r;
  pd_res_t                   res_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_e_r;
  logic signed [ACC_W-1:0]   acc_o_r;
  logic [15:0]               target_r;

  logic signed [MUL_W-1:0]   op_a;
  logic signed [MUL_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  mul;
  logic signed [PROD_W-1:0]  tsum;
  logic signed [ACC_W-1:0]   prod_x;
  logic [16:0]               sat_e;
  logic [16:0]               sat_o;

  function automatic logic [16:0] sat_q(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    begin
      r = (acc + ACC_W'(2048)) >>> 12;
      if (r > ACC_W'(32767)) begin
        sat_q = {1'b1, 16'h7FFF};
      end else if (r < -ACC_W'(32768)) begin
        sat_q = {1'b1, 16'h8000};
      end else begin
        sat_q = {1'b0, r[15:0]};
      end
    end
  endfunction

  // one shared multiplier, operands picked by step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      P_RNG: begin
        op_a = $signed({3'b000, req_r.range});
        op_b = $signed({2'b00, req_r.avg}) - 18'sd32768;
      end
      P_KDE: begin
        op_a = $signed({2'b00, req_r.kd});
        op_b = $signed({{2{req_r.spd_e[15]}}, req_r.spd_e});
      end
      P_KPE: begin
        op_a = $signed({2'b00, req_r.kp});
        op_b = $signed({{2{target_r[15]}}, target_r})
             - $signed({{2{req_r.ang_e[15]}}, req_r.ang_e});
      end
      P_KDO: begin
        op_a = $signed({2'b00, req_r.kd});
        op_b = $signed({{2{req_r.spd_o[15]}}, req_r.spd_o});
      end
      P_KPO: begin
        op_a = $signed({2'b00, req_r.kp});
        op_b = $signed({{2{target_r[15]}}, target_r})
             - $signed({{2{req_r.ang_o[15]}}, req_r.ang_o});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul    = op_a * op_b;
    tsum   = prod_r + PROD_W'(32768);
    prod_x = ACC_W'(prod_r);
    sat_e  = sat_q(acc_e_r);
    sat_o  = sat_q(acc_o_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= P_RNG;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        req_r  <= req;
        step_r <= P_RNG;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        case (step_r)
          P_RNG: begin
            prod_r <= mul;
            step_r <= P_KDE;
          end
          P_KDE: begin
            target_r <= tsum[31:16];
            prod_r   <= mul;
            step_r   <= P_KPE;
          end
          P_KPE: begin
            acc_e_r <= -(prod_x <<< 4);
            prod_r  <= mul;
            step_r  <= P_KDO;
          end
          P_KDO: begin
            acc_e_r <= acc_e_r + prod_x;
            prod_r  <= mul;
            step_r  <= P_KPO;
          end
          P_KPO: begin
            acc_o_r <= -(prod_x <<< 4);
            prod_r  <= mul;
            step_r  <= P_ACC;
          end
          P_ACC: begin
            acc_o_r <= acc_o_r + prod_x;
            step_r  <= P_FIN;
          end
          P_FIN: begin
            res_r.target   <= target_r;
            res_r.torque_e <= sat_e[15:0];
            res_r.torque_o <= sat_o[15:0];
            res_r.clip     <= sat_e[16] | sat_o[16];
            done_r         <= 1'b1;
            busy_r         <= 1'b0;
            step_r         <= P_RNG;
          end
          default: begin
            step_r <= P_RNG;
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: rtl/moving_average_pd_joint_control_top.sv
// channel | ports                      | beat contents
// input   | in_tvalid/tready/tdata/user | one control tick for one slider channel
// result  | out_tvalid/tready/tdata/user| filtered slider, target angle, two torques
// config  | cfg_we/addr/wdata          | one register write per cycle
//
// the next beat is accepted only once the result of the last one is loaded into
// the output register; each item goes through the channel record and ring reads,
// the bit-serial divide of the window sum by the fill count and the shared
// multiplier steps of the pd unit
// reset clears the channel records through valid bits; the ring needs no clear
// a result waits in the output register while the next beat is accepted

`timescale 1ns / 1ps
`default_nettype none

module moving_average_pd_joint_control_top
  import mapd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slider_sample, even_joint_angle, odd_joint_angle, even_joint_speed,
  // odd_joint_speed
  input  wire logic [79:0] in_tdata,
  // channel
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // filtered_slider, target_angle, even_joint_torque, odd_joint_torque
  output logic [63:0]      out_tdata,
  // channel_out, torque_clipped
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_META, S_RING, S_DIV, S_PD, S_OUT
  } state_t;

  state_t              state_r;

  logic [15:0]         kp_r;
  logic [15:0]         kd_r;
  logic [14:0]         range_r;
  logic [WL_W-1:0]     wl_r;

  logic [CIDX_W-1:0]   chan_r;
  logic [15:0]         smp_r;
  logic [15:0]         ang_e_r;
  logic [15:0]         ang_o_r;
  logic [15:0]         spd_e_r;
  logic [15:0]         spd_o_r;
  meta_t               meta_eff_r;
  logic                full_r;
  logic [15:0]         avg_r;

  logic                out_tvalid_r;
  logic [63:0]         out_tdata_r;
  logic [2:0]          out_tuser_r;

  // channel records and sample ring, both with a registered synchronous read
  meta_t               meta_mem [CHANNELS];
  meta_t               meta_q;
  logic [CHANNELS-1:0] meta_vld_r;
  logic [15:0]         ring [RING_DEPTH];
  logic [15:0]         ring_q;

  logic                in_acc;
  logic                out_load;
  logic [CIDX_W-1:0]   meta_ra;
  meta_t               meta_eff;
  meta_t               meta_wd;
  logic                meta_we;
  logic [CNT_W-1:0]    win;
  logic [SLOT_W+1:0]   old_t;
  logic [SLOT_W-1:0]   old_slot;
  logic [RA_W-1:0]     ring_base;
  logic [RA_W-1:0]     ring_ra;
  logic [RA_W-1:0]     ring_wa;
  logic                ring_we;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [SLOT_W-1:0]   slot_new;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [15:0]         avg_sat;
  logic                pd_start;
  logic                pd_done;
  pd_req_t             pd_req;
  pd_res_t             pd_res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    if (wl_r == '0) begin
      win = CNT_W'(1);
    end else if (32'(wl_r) > 32'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(wl_r);
    end

    meta_ra  = (state_r == S_IDLE) ? chan_idx(in_tuser) : chan_r;
    meta_eff = meta_vld_r[chan_r] ? meta_q : '0;

    // oldest sample sits fill-count slots behind the write slot
    old_t = (SLOT_W+2)'(meta_eff.slot) + (SLOT_W+2)'(MAX_WINDOW)
          - (SLOT_W+2)'(meta_eff.cnt);
    if (old_t >= (SLOT_W+2)'(MAX_WINDOW)) begin
      old_t = old_t - (SLOT_W+2)'(MAX_WINDOW);
    end
    old_slot = old_t[SLOT_W-1:0];

    ring_base = RA_W'(chan_r) * RA_W'(MAX_WINDOW);
    ring_ra   = ring_base + RA_W'(old_slot);
    ring_wa   = ring_base + RA_W'(meta_eff_r.slot);
    ring_we   = (state_r == S_RING);

    if (full_r) begin
      sum_new = meta_eff_r.sum - SUM_W'(ring_q) + SUM_W'(smp_r);
      cnt_new = meta_eff_r.cnt;
    end else begin
      sum_new = meta_eff_r.sum + SUM_W'(smp_r);
      cnt_new = meta_eff_r.cnt + 1'b1;
    end
    slot_new = (meta_eff_r.slot == SLOT_W'(MAX_WINDOW - 1)) ? '0
             : meta_eff_r.slot + 1'b1;

    meta_wd.sum  = sum_new;
    meta_wd.cnt  = cnt_new;
    meta_wd.slot = slot_new;
    meta_we      = (state_r == S_RING);
    div_start    = (state_r == S_RING);

    avg_sat  = (32'(div_quo) > 32'd65535) ? 16'hFFFF : div_quo[15:0];
    pd_start = (state_r == S_DIV) && div_done;

    pd_req.kp    = kp_r;
    pd_req.kd    = kd_r;
    pd_req.range = range_r;
    pd_req.avg   = avg_sat;
    pd_req.ang_e = ang_e_r;
    pd_req.ang_o = ang_o_r;
    pd_req.spd_e = spd_e_r;
    pd_req.spd_o = spd_o_r;
  end

  // channel record written back before the next beat is taken, so no
  // forwarding is needed
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[chan_r] <= meta_wd;
    end
    meta_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_wa] <= smp_r;
    end
    ring_q <= ring[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
    end else if (meta_we) begin
      meta_vld_r[chan_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= KP_RST;
      kd_r    <= KD_RST;
      range_r <= RANGE_RST;
      wl_r    <= WL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_KP:    kp_r    <= cfg_wdata;
        CFG_KD:    kd_r    <= cfg_wdata;
        CFG_RANGE: range_r <= cfg_wdata[14:0];
        CFG_WIN:   wl_r    <= cfg_wdata[WL_W-1:0];
        default:   kp_r    <= kp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            chan_r  <= chan_idx(in_tuser);
            smp_r   <= in_tdata[15:0];
            ang_e_r <= in_tdata[31:16];
            ang_o_r <= in_tdata[47:32];
            spd_e_r <= in_tdata[63:48];
            spd_o_r <= in_tdata[79:64];
            state_r <= S_META;
          end
        end
        S_META: begin
          meta_eff_r <= meta_eff;
          full_r     <= (meta_eff.cnt >= win);
          state_r    <= S_RING;
        end
        S_RING: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            avg_r   <= avg_sat;
            state_r <= S_PD;
          end
        end
        S_PD: begin
          if (pd_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_tdata_r  <= {pd_res.torque_o, pd_res.torque_e, pd_res.target, avg_r};
            out_tuser_r  <= {pd_res.clip, CH_W'(chan_r)};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  mapd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (cnt_new),
    .done     (div_done),
    .quotient (div_quo)
  );

  mapd_pd u_pd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pd_start),
    .req   (pd_req),
    .done  (pd_done),
    .res   (pd_res)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

FILE: rtl/mapd_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mapd_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // held result must not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one beat in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  // clip flag only with a torque at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      (out_tdata[47:32] == 16'h7FFF) || (out_tdata[47:32] == 16'h8000) ||
      (out_tdata[63:48] == 16'h7FFF) || (out_tdata[63:48] == 16'h8000))
    else $error("clip flag without saturated torque");

  // no result right out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind moving_average_pd_joint_control_top mapd_chk u_mapd_chk (.*);

`default_nettype wire
